/* hdl/frp_pkg.sv */
// frp_pkg: shared types and constants for the fast-packet reassembler
// no dependencies; imported by the core and the checker
package frp_pkg;

   localparam int FRAME_BYTES       = 8;
   localparam int FIRST_FRAME_BYTES = 6;
   localparam int NEXT_FRAME_BYTES  = 7;
   localparam int STREAM_LIMIT      = 64;

   localparam logic [4:0] INDEX_MASK = 5'h1F;
   localparam logic [7:0] FILL_MAX   = 8'hFF;

   localparam logic [2:0] STATUS_COMPLETE         = 3'd0;
   localparam logic [2:0] STATUS_INCOMPLETE       = 3'd1;
   localparam logic [2:0] STATUS_TOO_LONG         = 3'd2;
   localparam logic [2:0] STATUS_BAD_SEQUENCE     = 3'd3;
   localparam logic [2:0] STATUS_UNEXPECTED_INDEX = 3'd4;

   localparam logic [6:0] MAX_LENGTH_RESET = 7'd50;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WRITE,
      ST_DECIDE,
      ST_RESULT,
      ST_PREFETCH,
      ST_STREAM
   } frp_state_type;

   typedef logic [7:0][7:0] frame_type;

endpackage

/* hdl/frp_ram.sv */
// frp_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module frp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/fast_packet_reassembler_core.sv */
// fast_packet_reassembler_core: rebuilds multi-frame packets from can frame beats
// depends on frp_pkg and frp_ram (payload store)
//
// channel | dir | handshake              | content
// req     | in  | req_tvalid/req_tready  | tdata: frame bytes 0..7, byte 0 lowest
// rsp     | out | rsp_tvalid/rsp_tready  | tdata: status, out_byte, byte_index
//         |     |                        | tuser: byte_valid, tlast: last
// csr     | in  | csr_valid/csr_ready    | data: max_length
//
// per frame: idle, check, store (one byte per cycle through the
// single ram write port, 6 or 7 bytes), decide and result states
// a rejected frame skips store and decide
// a nonempty completing frame: prefetch and stream states in place of the result state
// synchronous active-high reset; the payload store needs no clearing pass
// a stalled rsp holds the result and stream states; req is taken only in the idle state
module fast_packet_reassembler_core
   import frp_pkg::*;
#(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // frame_byte0 .. frame_byte7, 8 bits each
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // status[2:0], out_byte[10:3], byte_index[16:11], zero
   output logic        rsp_tuser,   // byte_valid
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data
);

   localparam int AW         = $clog2(BUFFER_DEPTH);
   localparam int STREAM_CAP = (BUFFER_DEPTH < STREAM_LIMIT) ? BUFFER_DEPTH : STREAM_LIMIT;

   frp_state_type state_ff, state_in;
   frame_type     frame_ff;
   logic [6:0]    max_len_ff, max_len_in;
   logic [2:0]    seq_ff, seq_in;
   logic [4:0]    exp_ff, exp_in;
   logic [7:0]    fill_ff, fill_in;
   logic [7:0]    total_ff, total_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic [2:0]    src_ff, src_in;
   logic [2:0]    status_ff, status_in;
   logic [5:0]    k_ff, k_in;
   logic [6:0]    n_ff, n_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_bvalid_ff, rsp_bvalid_in;
   logic [5:0]    rsp_index_ff, rsp_index_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          req_fire;
   logic          out_free;
   logic          load;
   logic [2:0]    hdr_seq;
   logic [4:0]    hdr_idx;
   logic          in_store;
   logic          stream_last;
   logic [5:0]    k_next;
   logic [7:0]    rd_wide;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   frp_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign hdr_seq     = frame_ff[0][7:5];
   assign hdr_idx     = frame_ff[0][4:0] & INDEX_MASK;
   assign in_store    = ({1'b0, fill_ff} < 9'(BUFFER_DEPTH));
   assign stream_last = ((7'(k_ff) + 7'd1) == n_ff);
   assign k_next      = k_ff + 6'd1;

   assign wr_addr = fill_ff[AW-1:0];
   assign wr_data = frame_ff[src_ff];

   always_comb begin
      state_in      = state_ff;
      max_len_in    = max_len_ff;
      seq_in        = seq_ff;
      exp_in        = exp_ff;
      fill_in       = fill_ff;
      total_in      = total_ff;
      cnt_in        = cnt_ff;
      src_in        = src_ff;
      status_in     = status_ff;
      k_in          = k_ff;
      n_in          = n_ff;
      load          = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_wide       = 8'd0;

      if (csr_valid && csr_ready) begin
         max_len_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (hdr_idx == 5'd0) begin
               if (frame_ff[1] > {1'b0, max_len_ff}) begin
                  status_in = STATUS_TOO_LONG;
                  state_in  = ST_RESULT;
               end else begin
                  fill_in  = 8'd0;
                  src_in   = 3'd2;
                  cnt_in   = 3'(FIRST_FRAME_BYTES);
                  total_in = frame_ff[1];
                  seq_in   = hdr_seq;
                  exp_in   = 5'd1;
                  state_in = ST_WRITE;
               end
            end else if (hdr_seq != seq_ff) begin
               status_in = STATUS_BAD_SEQUENCE;
               state_in  = ST_RESULT;
            end else if (hdr_idx != exp_ff) begin
               status_in = STATUS_UNEXPECTED_INDEX;
               state_in  = ST_RESULT;
            end else begin
               exp_in   = (exp_ff + 5'd1) & INDEX_MASK;
               src_in   = 3'd1;
               cnt_in   = 3'(NEXT_FRAME_BYTES);
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            wr_en   = in_store;
            fill_in = (fill_ff == FILL_MAX) ? FILL_MAX : fill_ff + 8'd1;
            src_in  = src_ff + 3'd1;
            cnt_in  = cnt_ff - 3'd1;
            if (cnt_ff == 3'd1) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            n_in = (total_ff > 8'(STREAM_CAP)) ? 7'(STREAM_CAP) : total_ff[6:0];
            if (total_ff > fill_ff) begin
               status_in = STATUS_INCOMPLETE;
               state_in  = ST_RESULT;
            end else if (total_ff == 8'd0) begin
               status_in = STATUS_COMPLETE;
               state_in  = ST_RESULT;
            end else begin
               state_in = ST_PREFETCH;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_status_in = status_ff;
               rsp_byte_in   = 8'd0;
               rsp_bvalid_in = 1'b0;
               rsp_index_in  = 6'd0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_PREFETCH: begin
            rd_en    = 1'b1;
            k_in     = 6'd0;
            state_in = ST_STREAM;
         end
         ST_STREAM: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_status_in = STATUS_COMPLETE;
               rsp_byte_in   = rd_data;
               rsp_bvalid_in = 1'b1;
               rsp_index_in  = k_ff;
               rsp_last_in   = stream_last;
               if (stream_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_wide = {2'b00, k_next};
                  k_in    = k_next;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   assign rd_addr = rd_wide[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_len_ff   <= MAX_LENGTH_RESET;
         seq_ff       <= 3'd0;
         exp_ff       <= 5'd0;
         fill_ff      <= 8'd0;
         total_ff     <= 8'd0;
         cnt_ff       <= 3'd0;
         src_ff       <= 3'd0;
         k_ff         <= 6'd0;
         n_ff         <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_len_ff   <= max_len_in;
         seq_ff       <= seq_in;
         exp_ff       <= exp_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         cnt_ff       <= cnt_in;
         src_ff       <= src_in;
         k_ff         <= k_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         frame_ff <= req_tdata;
      end
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_index_ff, rsp_byte_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_bvalid_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* hdl/frp_checker.sv */
// frp_checker: port-level assertions for fast_packet_reassembler_core, with bind
// depends on frp_pkg and fast_packet_reassembler_core
module frp_checker
   import frp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // one frame at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken while a frame is in work");

   // a beat without a packet byte is the only beat of its frame
   a_status_beat_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata[16:3] == 14'd0))
      else $error("status beat not last or not cleared");

   // packet bytes only travel with complete status
   a_byte_complete: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[2:0] == STATUS_COMPLETE)
      else $error("packet byte with non-complete status");

endmodule

bind fast_packet_reassembler_core frp_checker u_frp_checker (.*);
